// ===== rtl/line_message_ring_buffer_macros.svh =====
// Assertion macros for the line message ring buffer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LINE_MESSAGE_RING_BUFFER_MACROS_SVH
`define LINE_MESSAGE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define LMRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define LMRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lmrb_pkg.sv =====
// Shared types and constants for the line message ring buffer.
// No dependencies; imported by every RTL module but lmrb_queue, and by the checker.
package lmrb_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 128;
  localparam int unsigned CMDQ_DEPTH      = 2;
  localparam int unsigned RESQ_DEPTH      = 2;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MAXLEN_W = 10;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = MAXLEN_W'(128);
  localparam logic [BYTE_W-1:0]   NEWLINE     = 8'h0A;

  // Request codes on in_kind
  localparam logic [KIND_W-1:0] KIND_RX      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;

  typedef enum logic [2:0] {
    OP_RX,
    OP_PEEK,
    OP_READ,
    OP_RELEASE,
    OP_FLUSH,
    OP_NONE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED = 3'd0,
    ST_QUEUED = 3'd1,
    ST_QDROP  = 3'd2,
    ST_RDROP  = 3'd3,
    ST_NOMSG  = 3'd4,
    ST_OK     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_EXEC,
    BK_READ_WAIT,
    BK_HEAD_WAIT
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
    logic              is_nl;
  } cmd_t;

endpackage

// ===== rtl/line_message_ring_buffer.sv =====
// Top level of the line message ring buffer: front end, execution side
// and result queue. Uses lmrb_pkg, lmrb_front, lmrb_back and lmrb_queue.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+------------------------
//   request  | in_kind, in_rx_byte, in_read_addr      | in_push / in_full
//   result   | out_status, out_head_start, ... fill   | out_empty / out_pop
//   config   | cfg_wdata (max_len)                    | cfg_we, no wait
//
// Receive, peek, flush and unknown requests, and releases with no message
// queued, finish in the execution stage; ring reads and other releases add
// a wait state for the registered read of the ring store or descriptor store.
// Command and result queues are registered. Reset is synchronous and clears
// all pointers and counts at once, with no clearing pass. Requests stall
// only when the two-entry command queue fills; execution holds while the
// two-entry result queue is full. RING_DEPTH and QUEUE_DEPTH are powers of two.
module line_message_ring_buffer
  import lmrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [MAXLEN_W-1:0]            cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [KIND_W-1:0]              in_kind,
  input  logic [BYTE_W-1:0]              in_rx_byte,
  input  logic [$clog2(RING_DEPTH)-1:0]  in_read_addr,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [STATUS_W-1:0]            out_status,
  output logic [$clog2(RING_DEPTH)-1:0]  out_head_start,
  output logic [$clog2(RING_DEPTH):0]    out_head_size,
  output logic [BYTE_W-1:0]              out_data_byte,
  output logic [$clog2(QUEUE_DEPTH):0]   out_queued_count,
  output logic [$clog2(RING_DEPTH):0]    out_ring_fill
);

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = PTR_W + 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH) + 1;
  localparam int unsigned RES_W  = STATUS_W + PTR_W + FILL_W + BYTE_W + QCNT_W + FILL_W;

  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;
  logic [PTR_W-1:0]  cmd_addr;

  logic              res_full, res_push;
  status_t           res_status;
  logic [PTR_W-1:0]  res_head_start;
  logic [FILL_W-1:0] res_head_size;
  logic [BYTE_W-1:0] res_data_byte;
  logic [QCNT_W-1:0] res_queued_count;
  logic [FILL_W-1:0] res_ring_fill;
  logic [RES_W-1:0]  res_rdata;

  lmrb_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .in_read_addr (in_read_addr),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_addr     (cmd_addr),
    .cmd_pop      (cmd_pop)
  );

  lmrb_back #(
    .RING_DEPTH  (RING_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_addr         (cmd_addr),
    .cmd_pop          (cmd_pop),
    .res_full         (res_full),
    .res_push         (res_push),
    .res_status       (res_status),
    .res_head_start   (res_head_start),
    .res_head_size    (res_head_size),
    .res_data_byte    (res_data_byte),
    .res_queued_count (res_queued_count),
    .res_ring_fill    (res_ring_fill)
  );

  lmrb_queue #(
    .WIDTH (RES_W),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_status, res_head_start, res_head_size, res_data_byte,
             res_queued_count, res_ring_fill}),
    .pop   (out_pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (out_empty)
  );

  assign {out_status, out_head_start, out_head_size, out_data_byte,
          out_queued_count, out_ring_fill} = res_rdata;

endmodule

// ===== rtl/lmrb_queue.sv =====
// Small register FIFO used between the pipeline parts.
// Depends on nothing but its parameters; DEPTH is a power of two.
module lmrb_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/lmrb_front.sv =====
// Front end: takes request transactions, decodes them into commands
// and buffers them for the execution side. Uses lmrb_pkg and lmrb_queue.
module lmrb_front
  import lmrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [KIND_W-1:0]             in_kind,
  input  logic [BYTE_W-1:0]             in_rx_byte,
  input  logic [$clog2(RING_DEPTH)-1:0] in_read_addr,
  output logic                          cmd_valid,
  output cmd_t                          cmd,
  output logic [$clog2(RING_DEPTH)-1:0] cmd_addr,
  input  logic                          cmd_pop
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned Q_W   = $bits(cmd_t) + PTR_W;

  cmd_t           dec;
  logic [Q_W-1:0] q_rdata;
  logic           q_empty;

  always_comb begin
    dec.rx_byte = in_rx_byte;
    dec.is_nl   = (in_rx_byte == NEWLINE);
    case (in_kind)
      KIND_RX:      dec.op = OP_RX;
      KIND_PEEK:    dec.op = OP_PEEK;
      KIND_READ:    dec.op = OP_READ;
      KIND_RELEASE: dec.op = OP_RELEASE;
      KIND_FLUSH:   dec.op = OP_FLUSH;
      default:      dec.op = OP_NONE;
    endcase
  end

  lmrb_queue #(
    .WIDTH (Q_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({dec, in_read_addr}),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .full  (in_full),
    .empty (q_empty)
  );

  assign cmd_valid       = !q_empty;
  assign {cmd, cmd_addr} = q_rdata;

endmodule

// ===== rtl/lmrb_back.sv =====
// Execution side: ring store, descriptor store and all pointer state.
// Uses lmrb_pkg; fed by lmrb_front, drains into the result queue.
module lmrb_back
  import lmrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [MAXLEN_W-1:0]              cfg_wdata,
  input  logic                             cmd_valid,
  input  cmd_t                             cmd,
  input  logic [$clog2(RING_DEPTH)-1:0]    cmd_addr,
  output logic                             cmd_pop,
  input  logic                             res_full,
  output logic                             res_push,
  output status_t                          res_status,
  output logic [$clog2(RING_DEPTH)-1:0]    res_head_start,
  output logic [$clog2(RING_DEPTH):0]      res_head_size,
  output logic [BYTE_W-1:0]                res_data_byte,
  output logic [$clog2(QUEUE_DEPTH):0]     res_queued_count,
  output logic [$clog2(RING_DEPTH):0]      res_ring_fill
);

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = PTR_W + 1;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;
  localparam int unsigned DESC_W = PTR_W + FILL_W;
  localparam int unsigned CMP_W  = (FILL_W > MAXLEN_W) ? FILL_W : MAXLEN_W;

  localparam logic [FILL_W-1:0] RING_FULL  = FILL_W'(RING_DEPTH);
  localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  // Stores
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  logic [DESC_W-1:0] desc_mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0] ring_rdata_r;
  logic [DESC_W-1:0] desc_rdata_r;

  logic              ring_we, ring_re;
  logic              desc_we, desc_re;
  logic [QPTR_W-1:0] desc_waddr, desc_raddr;
  logic [DESC_W-1:0] desc_wdata;

  // State
  bk_state_t           state_r, state_nxt;
  logic [MAXLEN_W-1:0] max_len_r;
  logic [PTR_W-1:0]    rp_r, rp_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]    ostart_r, ostart_nxt;
  logic [FILL_W-1:0]   osize_r, osize_nxt;
  logic [QPTR_W-1:0]   qhead_r, qhead_nxt;
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic [PTR_W-1:0]    hd_start_r, hd_start_nxt;
  logic [FILL_W-1:0]   hd_size_r, hd_size_nxt;

  // Receive arithmetic
  logic [FILL_W-1:0] drop;
  logic [PTR_W-1:0]  wp_inc;
  logic [FILL_W-1:0] os_inc;
  logic [FILL_W-1:0] fill_inc;
  logic [PTR_W-1:0]  wp_back;
  logic              close;

  always_comb begin
    drop     = (osize_r <= fill_r) ? osize_r : fill_r;
    wp_inc   = wp_r + PTR_W'(1);
    os_inc   = osize_r + FILL_W'(1);
    fill_inc = fill_r + FILL_W'(1);
    wp_back  = wp_inc - os_inc[PTR_W-1:0];
    close    = cmd.is_nl || (CMP_W'(os_inc) > CMP_W'(max_len_r)) || (fill_inc == RING_FULL);
  end

  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    ostart_nxt   = ostart_r;
    osize_nxt    = osize_r;
    qhead_nxt    = qhead_r;
    qcnt_nxt     = qcnt_r;
    hd_start_nxt = hd_start_r;
    hd_size_nxt  = hd_size_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_status   = ST_NOMSG;
    res_data_byte = '0;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    desc_we      = 1'b0;
    desc_re      = 1'b0;
    desc_waddr   = qhead_r + qcnt_r[QPTR_W-1:0];
    desc_wdata   = {ostart_r, os_inc};
    desc_raddr   = qhead_r + QPTR_W'(1);

    case (state_r)
      BK_EXEC: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_RX: begin
              res_push = 1'b1;
              if (fill_r == RING_FULL) begin
                // ring full: drop the byte and discard the open message
                wp_nxt     = wp_r - drop[PTR_W-1:0];
                fill_nxt   = fill_r - drop;
                osize_nxt  = '0;
                res_status = ST_RDROP;
              end else begin
                ring_we    = 1'b1;
                wp_nxt     = wp_inc;
                fill_nxt   = fill_inc;
                osize_nxt  = os_inc;
                res_status = ST_STORED;
                if (close) begin
                  osize_nxt = '0;
                  if (qcnt_r == QUEUE_FULL) begin
                    // no descriptor slot: roll the message back out
                    wp_nxt     = wp_back;
                    fill_nxt   = fill_inc - os_inc;
                    ostart_nxt = wp_back;
                    res_status = ST_QDROP;
                  end else begin
                    ostart_nxt = wp_inc;
                    desc_we    = 1'b1;
                    qcnt_nxt   = qcnt_r + QCNT_W'(1);
                    res_status = ST_QUEUED;
                    if (qcnt_r == '0) begin
                      hd_start_nxt = ostart_r;
                      hd_size_nxt  = os_inc;
                    end
                  end
                end
              end
            end
            OP_PEEK: begin
              res_push   = 1'b1;
              res_status = (qcnt_r != '0) ? ST_OK : ST_NOMSG;
            end
            OP_READ: begin
              ring_re   = 1'b1;
              state_nxt = BK_READ_WAIT;
            end
            OP_RELEASE: begin
              if (qcnt_r != '0) begin
                if (hd_start_r == rp_r && hd_size_r <= fill_r) begin
                  rp_nxt   = rp_r + hd_size_r[PTR_W-1:0];
                  fill_nxt = fill_r - hd_size_r;
                end
                qhead_nxt = qhead_r + QPTR_W'(1);
                qcnt_nxt  = qcnt_r - QCNT_W'(1);
                desc_re   = 1'b1;
                state_nxt = BK_HEAD_WAIT;
              end else begin
                res_push   = 1'b1;
                res_status = ST_NOMSG;
              end
            end
            OP_FLUSH: begin
              // queued messages sit back to back from rp up to the open message
              rp_nxt     = ostart_r;
              fill_nxt   = osize_r;
              qhead_nxt  = qhead_r + qcnt_r[QPTR_W-1:0];
              qcnt_nxt   = '0;
              res_push   = 1'b1;
              res_status = ST_OK;
            end
            default: begin
              res_push   = 1'b1;
              res_status = ST_NOMSG;
            end
          endcase
        end
      end
      BK_READ_WAIT: begin
        res_push      = 1'b1;
        res_status    = ST_OK;
        res_data_byte = ring_rdata_r;
        state_nxt     = BK_EXEC;
      end
      BK_HEAD_WAIT: begin
        {hd_start_nxt, hd_size_nxt} = desc_rdata_r;
        res_push   = 1'b1;
        res_status = ST_OK;
        state_nxt  = BK_EXEC;
      end
      default: begin
        state_nxt = BK_EXEC;
      end
    endcase

    res_head_start   = (qcnt_nxt != '0) ? hd_start_nxt : '0;
    res_head_size    = (qcnt_nxt != '0) ? hd_size_nxt : '0;
    res_queued_count = qcnt_nxt;
    res_ring_fill    = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_EXEC;
      max_len_r <= MAX_LEN_RST;
      rp_r      <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      ostart_r  <= '0;
      osize_r   <= '0;
      qhead_r   <= '0;
      qcnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      ostart_r <= ostart_nxt;
      osize_r  <= osize_nxt;
      qhead_r  <= qhead_nxt;
      qcnt_r   <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hd_start_r <= hd_start_nxt;
    hd_size_r  <= hd_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= cmd.rx_byte;
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[cmd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    if (desc_re) begin
      desc_rdata_r <= desc_mem[desc_raddr];
    end
  end

endmodule

// ===== rtl/lmrb_checker.sv =====
// Port-level checks for the line message ring buffer, bound to the top level.
// Uses lmrb_pkg and line_message_ring_buffer_macros.svh.
`include "line_message_ring_buffer_macros.svh"

module lmrb_checker
  import lmrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic [STATUS_W-1:0]            out_status,
  input logic [$clog2(RING_DEPTH)-1:0]  out_head_start,
  input logic [$clog2(RING_DEPTH):0]    out_head_size,
  input logic [BYTE_W-1:0]              out_data_byte,
  input logic [$clog2(QUEUE_DEPTH):0]   out_queued_count,
  input logic [$clog2(RING_DEPTH):0]    out_ring_fill
);

  localparam int unsigned FILL_W = $clog2(RING_DEPTH) + 1;
  localparam logic [FILL_W-1:0] RING_FULL = FILL_W'(RING_DEPTH);

  `LMRB_ASSERT_NEXT(a_reset_clears, !rst_n, out_empty && !in_full, "reset left queues busy")

  `LMRB_ASSERT_IMP(a_no_head_when_empty, !out_empty && out_queued_count == '0,
    out_head_start == '0 && out_head_size == '0, "head fields set with no message")

  `LMRB_ASSERT_IMP(a_head_fits, !out_empty && out_queued_count != '0,
    out_head_size != '0 && out_head_size <= out_ring_fill, "head size outside ring fill")

  `LMRB_ASSERT_IMP(a_stored_open, !out_empty && out_status == ST_STORED,
    out_ring_fill != '0 && out_ring_fill != RING_FULL, "stored byte with bad ring fill")

  `LMRB_ASSERT_IMP(a_data_only_ok, !out_empty && out_status != ST_OK,
    out_data_byte == '0, "data byte on a non-read result")

endmodule

bind line_message_ring_buffer lmrb_checker #(
  .RING_DEPTH  (RING_DEPTH),
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lmrb_checker (.*);

// ===== tb/line_message_ring_buffer_test.sv =====
// Self-checking bench for line_message_ring_buffer: a tracker of the byte ring
// and descriptor queue predicts every reply, and replies are checked in order.
// Depends on lmrb_pkg and the line_message_ring_buffer RTL.
module line_message_ring_buffer_test;
  import lmrb_pkg::*;

  localparam int unsigned RING_N        = RING_DEPTH_DEF;
  localparam int unsigned QUEUE_N       = QUEUE_DEPTH_DEF;
  localparam int unsigned RA_W          = $clog2(RING_N);
  localparam int unsigned QA_W          = $clog2(QUEUE_N);
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;

  // Request codes the block does not decode; they get a no-message reply
  localparam logic [KIND_W-1:0] KIND_UNDEF_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNDEF_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNDEF_LAST  = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [RA_W-1:0]     head_start;
    logic [RA_W:0]       head_size;
    logic [BYTE_W-1:0]   data_byte;
    logic [QA_W:0]       queued_count;
    logic [RA_W:0]       ring_fill;
  } ring_reply_t;

  class msg_ring_tracker;
    logic [BYTE_W-1:0]   ring_bytes [RING_N];
    bit                  written [RING_N];
    int unsigned         written_addrs [$];
    logic [RA_W-1:0]     rd_ptr;
    logic [RA_W-1:0]     wr_ptr;
    logic [RA_W-1:0]     open_start;
    logic [RA_W:0]       fill;
    logic [RA_W:0]       open_size;
    logic [RA_W-1:0]     desc_start [QUEUE_N];
    logic [RA_W:0]       desc_size [QUEUE_N];
    logic [QA_W-1:0]     q_head;
    logic [QA_W:0]       q_count;
    logic [MAXLEN_W-1:0] max_len;
    ring_reply_t         pending_replies [$];
    int unsigned         errors;

    function new();
      rd_ptr     = '0;
      wr_ptr     = '0;
      open_start = '0;
      fill       = '0;
      open_size  = '0;
      q_head     = '0;
      q_count    = '0;
      max_len    = MAX_LEN_RST;
      errors     = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function status_t receive(logic [BYTE_W-1:0] rx);
      logic [RA_W:0]   msg_len;
      logic [QA_W-1:0] slot;
      if (fill >= RING_N) begin
        // drop the byte and discard the open partial message
        msg_len = (open_size <= fill) ? open_size : fill;
        wr_ptr = wr_ptr - msg_len[RA_W-1:0];
        fill = fill - msg_len;
        open_size = '0;
        return ST_RDROP;
      end
      ring_bytes[wr_ptr] = rx;
      if (!written[wr_ptr]) begin
        written[wr_ptr] = 1'b1;
        written_addrs.push_back(32'(wr_ptr));
      end
      wr_ptr = wr_ptr + 1'b1;
      open_size = open_size + 1'b1;
      fill = fill + 1'b1;
      if (rx == NEWLINE || open_size > max_len || fill == RING_N) begin
        msg_len = open_size;
        open_size = '0;
        if (q_count >= QUEUE_N) begin
          // no descriptor slot: roll the message back out of the ring
          wr_ptr = wr_ptr - msg_len[RA_W-1:0];
          fill = fill - msg_len;
          open_start = wr_ptr;
          return ST_QDROP;
        end
        slot = q_head + q_count[QA_W-1:0];
        desc_start[slot] = open_start;
        desc_size[slot] = msg_len;
        open_start = wr_ptr;
        q_count = q_count + 1'b1;
        return ST_QUEUED;
      end
      return ST_STORED;
    endfunction

    function void release_head();
      // free the bytes only when the message sits at the read pointer
      if (desc_start[q_head] == rd_ptr && desc_size[q_head] <= fill) begin
        rd_ptr = rd_ptr + desc_size[q_head][RA_W-1:0];
        fill = fill - desc_size[q_head];
      end
      q_head = q_head + 1'b1;
      q_count = q_count - 1'b1;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rx,
                               logic [RA_W-1:0] addr);
      ring_reply_t want;
      status_t     st;
      st = ST_NOMSG;
      want.data_byte = '0;
      case (kind)
        KIND_RX: begin
          st = receive(rx);
        end
        KIND_PEEK: begin
          if (q_count != 0) st = ST_OK;
        end
        KIND_READ: begin
          want.data_byte = ring_bytes[addr];
          st = ST_OK;
        end
        KIND_RELEASE: begin
          if (q_count != 0) begin
            release_head();
            st = ST_OK;
          end
        end
        KIND_FLUSH: begin
          while (q_count != 0) release_head();
          st = ST_OK;
        end
        default: ;
      endcase
      want.status       = st;
      want.head_start   = (q_count != 0) ? desc_start[q_head] : '0;
      want.head_size    = (q_count != 0) ? desc_size[q_head] : '0;
      want.queued_count = q_count;
      want.ring_fill    = fill;
      pending_replies.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(ring_reply_t got);
      ring_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding, status %0d", got.status);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("head_start", 16'(want.head_start), 16'(got.head_start));
      compare_field("head_size", 16'(want.head_size), 16'(got.head_size));
      compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare_field("queued_count", 16'(want.queued_count), 16'(got.queued_count));
      compare_field("ring_fill", 16'(want.ring_fill), 16'(got.ring_fill));
    endfunction

    function int random_written_addr();
      if (written_addrs.size() == 0) return -1;
      return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [MAXLEN_W-1:0] cfg_wdata    = '0;
  logic                in_push      = 1'b0;
  logic                in_full;
  logic [KIND_W-1:0]   in_kind      = '0;
  logic [BYTE_W-1:0]   in_rx_byte   = '0;
  logic [RA_W-1:0]     in_read_addr = '0;
  logic                out_empty;
  logic                out_pop      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [RA_W-1:0]     out_head_start;
  logic [RA_W:0]       out_head_size;
  logic [BYTE_W-1:0]   out_data_byte;
  logic [QA_W:0]       out_queued_count;
  logic [RA_W:0]       out_ring_fill;

  msg_ring_tracker tracker = new();
  bit              steady  = 1'b0;

  line_message_ring_buffer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .in_read_addr     (in_read_addr),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_head_start   (out_head_start),
    .out_head_size    (out_head_size),
    .out_data_byte    (out_data_byte),
    .out_queued_count (out_queued_count),
    .out_ring_fill    (out_ring_fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rx,
                       logic [RA_W-1:0] addr);
    int unsigned gap;
    in_kind      <= kind;
    in_rx_byte   <= rx;
    in_read_addr <= addr;
    in_push      <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.note_request(kind, rx, addr);
    gap = pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off requests until every reply is back and the pipeline is empty.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(logic [MAXLEN_W-1:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.max_len = value;
  endtask

  task automatic run_traffic(int unsigned rx_target, int unsigned rx_pct,
                             int unsigned nl_pct, bit releases);
    int unsigned       rx_done;
    int unsigned       count;
    int unsigned       roll;
    int                addr;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] rx;
    rx_done = 0;
    count = 0;
    while (rx_done < rx_target) begin
      if (count % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      count++;
      rx = BYTE_W'($urandom_range(0, 255));
      addr = $urandom_range(0, RING_N - 1);
      roll = $urandom_range(0, 99);
      if (roll < rx_pct) begin
        kind = KIND_RX;
        if ($urandom_range(0, 99) < nl_pct) rx = NEWLINE;
        rx_done++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          kind = KIND_PEEK;
        end else if (roll < 65) begin
          // read only entries that have been written at least once
          kind = KIND_READ;
          addr = tracker.random_written_addr();
          if (addr < 0) kind = KIND_PEEK;
        end else if (roll < 88) begin
          kind = releases ? KIND_RELEASE : KIND_PEEK;
        end else if (roll < 93) begin
          kind = releases ? KIND_FLUSH : KIND_PEEK;
        end else begin
          kind = KIND_W'($urandom_range(KIND_UNDEF_FIRST, KIND_UNDEF_LAST));
        end
      end
      issue(kind, rx, addr[RA_W-1:0]);
    end
  endtask

  initial begin : reply_drain
    int unsigned stall;
    ring_reply_t got;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.status       = out_status;
        got.head_start   = out_head_start;
        got.head_size    = out_head_size;
        got.data_byte    = out_data_byte;
        got.queued_count = out_queued_count;
        got.ring_fill    = out_ring_fill;
        tracker.check_reply(got);
      end
      if (stall != 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[line_message_ring_buffer] ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-queue requests and ignored codes
    issue(KIND_PEEK, 8'h00, '0);
    issue(KIND_RELEASE, 8'hFF, '1);
    issue(KIND_FLUSH, 8'h00, '0);
    issue(KIND_UNDEF_FIRST, 8'h00, '0);
    issue(KIND_UNDEF_MID, 8'h00, '0);
    issue(KIND_UNDEF_LAST, 8'hFF, '1);
    // Messages closed by newline, peeked, read back and released
    issue(KIND_RX, 8'h00, '0);
    issue(KIND_RX, 8'hFF, '0);
    issue(KIND_READ, 8'h00, 10'd0);
    issue(KIND_READ, 8'h00, 10'd1);
    issue(KIND_RX, NEWLINE, '0);
    issue(KIND_PEEK, 8'h00, '0);
    issue(KIND_RX, 8'h55, '0);
    issue(KIND_RX, 8'hAA, '0);
    issue(KIND_RX, NEWLINE, '0);
    issue(KIND_PEEK, 8'h00, '0);
    issue(KIND_RELEASE, 8'h00, '0);
    issue(KIND_READ, 8'h00, 10'd4);
    issue(KIND_RX, 8'h80, '0);
    issue(KIND_RX, 8'h7F, '0);
    // flush with an open partial message, then close it
    issue(KIND_FLUSH, 8'h00, '0);
    issue(KIND_RX, NEWLINE, '0);
    issue(KIND_RELEASE, 8'h00, '0);

    run_traffic(30, 60, 10, 1'b1);

    // Every byte closes a message; the descriptor queue overflows
    write_max_len('0);
    run_traffic(140, 95, 5, 1'b0);
    issue(KIND_FLUSH, 8'h00, '0);

    // Long messages with no release: the ring fills and bytes get dropped
    write_max_len(10'd1023);
    run_traffic(1040, 98, 1, 1'b0);
    issue(KIND_READ, 8'h00, '0);
    issue(KIND_READ, 8'h00, '1);
    issue(KIND_FLUSH, 8'h00, '0);

    write_max_len(10'd1);
    run_traffic(20, 60, 10, 1'b1);

    write_max_len(MAXLEN_W'($urandom_range(2, 40)));
    run_traffic(20, 60, 8, 1'b1);

    settle();
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("[line_message_ring_buffer] OK");
    end else begin
      $display("[line_message_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule
